// ----- src/cpc_pkg.sv -----
// Package with character codes, token codes and lookup functions for the punctuator classifier.
`timescale 1ns / 1ps
`default_nettype none

package cpc_pkg;

  localparam int unsigned CharW  = 21;
  localparam int unsigned TokW   = 6;
  localparam int unsigned FlagsW = 22;
  localparam int unsigned LenW   = 2;

  localparam logic [CharW-1:0] CH_EXCL   = 21'h21;
  localparam logic [CharW-1:0] CH_HASH   = 21'h23;
  localparam logic [CharW-1:0] CH_PCT    = 21'h25;
  localparam logic [CharW-1:0] CH_AMP    = 21'h26;
  localparam logic [CharW-1:0] CH_LPAREN = 21'h28;
  localparam logic [CharW-1:0] CH_RPAREN = 21'h29;
  localparam logic [CharW-1:0] CH_STAR   = 21'h2A;
  localparam logic [CharW-1:0] CH_PLUS   = 21'h2B;
  localparam logic [CharW-1:0] CH_COMMA  = 21'h2C;
  localparam logic [CharW-1:0] CH_MINUS  = 21'h2D;
  localparam logic [CharW-1:0] CH_DOT    = 21'h2E;
  localparam logic [CharW-1:0] CH_SLASH  = 21'h2F;
  localparam logic [CharW-1:0] CH_COLON  = 21'h3A;
  localparam logic [CharW-1:0] CH_SEMI   = 21'h3B;
  localparam logic [CharW-1:0] CH_LT     = 21'h3C;
  localparam logic [CharW-1:0] CH_EQ     = 21'h3D;
  localparam logic [CharW-1:0] CH_GT     = 21'h3E;
  localparam logic [CharW-1:0] CH_QUEST  = 21'h3F;
  localparam logic [CharW-1:0] CH_LBRACK = 21'h5B;
  localparam logic [CharW-1:0] CH_BSLASH = 21'h5C;
  localparam logic [CharW-1:0] CH_RBRACK = 21'h5D;
  localparam logic [CharW-1:0] CH_CARET  = 21'h5E;
  localparam logic [CharW-1:0] CH_LBRACE = 21'h7B;
  localparam logic [CharW-1:0] CH_PIPE   = 21'h7C;
  localparam logic [CharW-1:0] CH_RBRACE = 21'h7D;
  localparam logic [CharW-1:0] CH_TILDE  = 21'h7E;

  localparam logic [FlagsW-1:0] FL_NONE      = 22'h000000;
  localparam logic [FlagsW-1:0] FL_COMPARE   = 22'h000001;
  localparam logic [FlagsW-1:0] FL_PREFIX    = 22'h000002;
  localparam logic [FlagsW-1:0] FL_TWO_OPS   = 22'h000004;
  localparam logic [FlagsW-1:0] FL_ASSIGN    = 22'h000008;
  localparam logic [FlagsW-1:0] FL_INFIX     = 22'h000010;
  localparam logic [FlagsW-1:0] FL_PTR_REF   = 22'h000020;
  localparam logic [FlagsW-1:0] FL_PAREN_O   = 22'h000040;
  localparam logic [FlagsW-1:0] FL_PAREN_C   = 22'h000080;
  localparam logic [FlagsW-1:0] FL_ASTERISK  = 22'h000100;
  localparam logic [FlagsW-1:0] FL_INCDEC    = 22'h000200;
  localparam logic [FlagsW-1:0] FL_COMMA     = 22'h000400;
  localparam logic [FlagsW-1:0] FL_STRUCT    = 22'h000800;
  localparam logic [FlagsW-1:0] FL_POINTER   = 22'h001000;
  localparam logic [FlagsW-1:0] FL_ELLIPSIS  = 22'h002000;
  localparam logic [FlagsW-1:0] FL_COLON     = 22'h004000;
  localparam logic [FlagsW-1:0] FL_SEMICOLON = 22'h008000;
  localparam logic [FlagsW-1:0] FL_QUESTION  = 22'h010000;
  localparam logic [FlagsW-1:0] FL_BRACK_O   = 22'h020000;
  localparam logic [FlagsW-1:0] FL_BACKSLASH = 22'h040000;
  localparam logic [FlagsW-1:0] FL_BRACK_C   = 22'h080000;
  localparam logic [FlagsW-1:0] FL_BRACE_O   = 22'h100000;
  localparam logic [FlagsW-1:0] FL_BRACE_C   = 22'h200000;

  localparam logic [LenW-1:0] LEN_ONE   = 2'd1;
  localparam logic [LenW-1:0] LEN_TWO   = 2'd2;
  localparam logic [LenW-1:0] LEN_THREE = 2'd3;

  typedef enum logic [TokW-1:0] {
    TOK_NE        = 6'd0,
    TOK_NOT       = 6'd1,
    TOK_HASHHASH  = 6'd2,
    TOK_HASH      = 6'd3,
    TOK_MOD_ASGN  = 6'd4,
    TOK_MOD       = 6'd5,
    TOK_ANDAND    = 6'd6,
    TOK_AND_ASGN  = 6'd7,
    TOK_AMP       = 6'd8,
    TOK_LPAREN    = 6'd9,
    TOK_RPAREN    = 6'd10,
    TOK_MUL_ASGN  = 6'd11,
    TOK_STAR      = 6'd12,
    TOK_INC       = 6'd13,
    TOK_ADD_ASGN  = 6'd14,
    TOK_PLUS      = 6'd15,
    TOK_COMMA     = 6'd16,
    TOK_DEC       = 6'd17,
    TOK_SUB_ASGN  = 6'd18,
    TOK_ARROW     = 6'd19,
    TOK_MINUS     = 6'd20,
    TOK_ELLIPSIS  = 6'd21,
    TOK_DOTDOT    = 6'd22,
    TOK_DOT       = 6'd23,
    TOK_DIV_ASGN  = 6'd24,
    TOK_DIV       = 6'd25,
    TOK_COLON     = 6'd26,
    TOK_SEMI      = 6'd27,
    TOK_SHL_ASGN  = 6'd28,
    TOK_SHL       = 6'd29,
    TOK_LE        = 6'd30,
    TOK_LT        = 6'd31,
    TOK_EQEQ      = 6'd32,
    TOK_ASGN      = 6'd33,
    TOK_SHR_ASGN  = 6'd34,
    TOK_SHR       = 6'd35,
    TOK_GE        = 6'd36,
    TOK_GT        = 6'd37,
    TOK_QUEST     = 6'd38,
    TOK_LBRACK    = 6'd39,
    TOK_BSLASH    = 6'd40,
    TOK_RBRACK    = 6'd41,
    TOK_XOR_ASGN  = 6'd42,
    TOK_XOR       = 6'd43,
    TOK_LBRACE    = 6'd44,
    TOK_OR_ASGN   = 6'd45,
    TOK_OROR      = 6'd46,
    TOK_PIPE      = 6'd47,
    TOK_RBRACE    = 6'd48,
    TOK_TILDE     = 6'd49,
    TOK_INVALID   = 6'd50
  } token_e;

  typedef struct packed {
    logic [TokW-1:0]   token;
    logic [FlagsW-1:0] flags;
    logic [LenW-1:0]   consumed;
    logic              invalid;
  } result_t;

  function automatic logic [FlagsW-1:0] token_flags(input token_e tok);
    logic [FlagsW-1:0] fl;
    case (tok) inside
      TOK_NE, TOK_LE, TOK_LT, TOK_EQEQ, TOK_GE, TOK_GT: fl = FL_COMPARE;
      TOK_NOT, TOK_TILDE: fl = FL_PREFIX;
      TOK_HASHHASH: fl = FL_TWO_OPS;
      TOK_MOD_ASGN, TOK_AND_ASGN, TOK_MUL_ASGN, TOK_ADD_ASGN, TOK_SUB_ASGN,
      TOK_DIV_ASGN, TOK_SHL_ASGN, TOK_ASGN, TOK_SHR_ASGN, TOK_XOR_ASGN,
      TOK_OR_ASGN: fl = FL_ASSIGN;
      TOK_MOD, TOK_ANDAND, TOK_PLUS, TOK_MINUS, TOK_DIV, TOK_SHL, TOK_SHR,
      TOK_XOR, TOK_OROR, TOK_PIPE: fl = FL_INFIX;
      TOK_AMP: fl = FL_INFIX | FL_PTR_REF;
      TOK_LPAREN: fl = FL_PAREN_O;
      TOK_RPAREN: fl = FL_PAREN_C;
      TOK_STAR: fl = FL_ASTERISK;
      TOK_INC, TOK_DEC: fl = FL_INCDEC;
      TOK_COMMA: fl = FL_COMMA;
      TOK_ARROW: fl = FL_STRUCT | FL_POINTER;
      TOK_DOT: fl = FL_STRUCT;
      TOK_ELLIPSIS: fl = FL_ELLIPSIS;
      TOK_COLON: fl = FL_COLON;
      TOK_SEMI: fl = FL_SEMICOLON;
      TOK_QUEST: fl = FL_QUESTION;
      TOK_LBRACK: fl = FL_BRACK_O;
      TOK_BSLASH: fl = FL_BACKSLASH;
      TOK_RBRACK: fl = FL_BRACK_C;
      TOK_LBRACE: fl = FL_BRACE_O;
      TOK_RBRACE: fl = FL_BRACE_C;
      default: fl = FL_NONE;
    endcase
    return fl;
  endfunction

  function automatic logic [LenW-1:0] token_len(input token_e tok);
    logic [LenW-1:0] len;
    case (tok) inside
      TOK_ELLIPSIS, TOK_SHL_ASGN, TOK_SHR_ASGN: len = LEN_THREE;
      TOK_NE, TOK_HASHHASH, TOK_MOD_ASGN, TOK_ANDAND, TOK_AND_ASGN, TOK_MUL_ASGN,
      TOK_INC, TOK_ADD_ASGN, TOK_DEC, TOK_SUB_ASGN, TOK_ARROW, TOK_DOTDOT,
      TOK_DIV_ASGN, TOK_SHL, TOK_LE, TOK_EQEQ, TOK_SHR, TOK_GE, TOK_XOR_ASGN,
      TOK_OR_ASGN, TOK_OROR: len = LEN_TWO;
      default: len = LEN_ONE;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ----- src/cpc_classify.sv -----
// Longest-match decoder that maps three characters to a punctuator result.
`timescale 1ns / 1ps
`default_nettype none

module cpc_classify (
  input  wire logic [cpc_pkg::CharW-1:0] first_char_i,
  input  wire logic [cpc_pkg::CharW-1:0] second_char_i,
  input  wire logic [cpc_pkg::CharW-1:0] third_char_i,
  output cpc_pkg::result_t               result_o
);

  cpc_pkg::token_e tok;
  logic b_eq, b_plus, b_minus, b_amp, b_gt, b_lt, b_dot, b_pipe, b_hash;
  logic c_eq, c_dot;

  assign b_eq    = (second_char_i == cpc_pkg::CH_EQ);
  assign b_plus  = (second_char_i == cpc_pkg::CH_PLUS);
  assign b_minus = (second_char_i == cpc_pkg::CH_MINUS);
  assign b_amp   = (second_char_i == cpc_pkg::CH_AMP);
  assign b_gt    = (second_char_i == cpc_pkg::CH_GT);
  assign b_lt    = (second_char_i == cpc_pkg::CH_LT);
  assign b_dot   = (second_char_i == cpc_pkg::CH_DOT);
  assign b_pipe  = (second_char_i == cpc_pkg::CH_PIPE);
  assign b_hash  = (second_char_i == cpc_pkg::CH_HASH);
  assign c_eq    = (third_char_i == cpc_pkg::CH_EQ);
  assign c_dot   = (third_char_i == cpc_pkg::CH_DOT);

  always_comb begin
    unique case (first_char_i)
      cpc_pkg::CH_EXCL:   tok = b_eq ? cpc_pkg::TOK_NE : cpc_pkg::TOK_NOT;
      cpc_pkg::CH_HASH:   tok = b_hash ? cpc_pkg::TOK_HASHHASH : cpc_pkg::TOK_HASH;
      cpc_pkg::CH_PCT:    tok = b_eq ? cpc_pkg::TOK_MOD_ASGN : cpc_pkg::TOK_MOD;
      cpc_pkg::CH_AMP: begin
        tok = b_amp ? cpc_pkg::TOK_ANDAND :
              b_eq  ? cpc_pkg::TOK_AND_ASGN : cpc_pkg::TOK_AMP;
      end
      cpc_pkg::CH_LPAREN: tok = cpc_pkg::TOK_LPAREN;
      cpc_pkg::CH_RPAREN: tok = cpc_pkg::TOK_RPAREN;
      cpc_pkg::CH_STAR:   tok = b_eq ? cpc_pkg::TOK_MUL_ASGN : cpc_pkg::TOK_STAR;
      cpc_pkg::CH_PLUS: begin
        tok = b_plus ? cpc_pkg::TOK_INC :
              b_eq   ? cpc_pkg::TOK_ADD_ASGN : cpc_pkg::TOK_PLUS;
      end
      cpc_pkg::CH_COMMA:  tok = cpc_pkg::TOK_COMMA;
      cpc_pkg::CH_MINUS: begin
        tok = b_minus ? cpc_pkg::TOK_DEC :
              b_eq    ? cpc_pkg::TOK_SUB_ASGN :
              b_gt    ? cpc_pkg::TOK_ARROW : cpc_pkg::TOK_MINUS;
      end
      cpc_pkg::CH_DOT: begin
        tok = !b_dot ? cpc_pkg::TOK_DOT :
              c_dot  ? cpc_pkg::TOK_ELLIPSIS : cpc_pkg::TOK_DOTDOT;
      end
      cpc_pkg::CH_SLASH:  tok = b_eq ? cpc_pkg::TOK_DIV_ASGN : cpc_pkg::TOK_DIV;
      cpc_pkg::CH_COLON:  tok = cpc_pkg::TOK_COLON;
      cpc_pkg::CH_SEMI:   tok = cpc_pkg::TOK_SEMI;
      cpc_pkg::CH_LT: begin
        tok = b_lt ? (c_eq ? cpc_pkg::TOK_SHL_ASGN : cpc_pkg::TOK_SHL) :
              b_eq ? cpc_pkg::TOK_LE : cpc_pkg::TOK_LT;
      end
      cpc_pkg::CH_EQ:     tok = b_eq ? cpc_pkg::TOK_EQEQ : cpc_pkg::TOK_ASGN;
      cpc_pkg::CH_GT: begin
        tok = b_gt ? (c_eq ? cpc_pkg::TOK_SHR_ASGN : cpc_pkg::TOK_SHR) :
              b_eq ? cpc_pkg::TOK_GE : cpc_pkg::TOK_GT;
      end
      cpc_pkg::CH_QUEST:  tok = cpc_pkg::TOK_QUEST;
      cpc_pkg::CH_LBRACK: tok = cpc_pkg::TOK_LBRACK;
      cpc_pkg::CH_BSLASH: tok = cpc_pkg::TOK_BSLASH;
      cpc_pkg::CH_RBRACK: tok = cpc_pkg::TOK_RBRACK;
      cpc_pkg::CH_CARET:  tok = b_eq ? cpc_pkg::TOK_XOR_ASGN : cpc_pkg::TOK_XOR;
      cpc_pkg::CH_LBRACE: tok = cpc_pkg::TOK_LBRACE;
      cpc_pkg::CH_PIPE: begin
        tok = b_eq   ? cpc_pkg::TOK_OR_ASGN :
              b_pipe ? cpc_pkg::TOK_OROR : cpc_pkg::TOK_PIPE;
      end
      cpc_pkg::CH_RBRACE: tok = cpc_pkg::TOK_RBRACE;
      cpc_pkg::CH_TILDE:  tok = cpc_pkg::TOK_TILDE;
      default:            tok = cpc_pkg::TOK_INVALID;
    endcase
  end

  assign result_o.token    = tok;
  assign result_o.flags    = cpc_pkg::token_flags(tok);
  assign result_o.consumed = cpc_pkg::token_len(tok);
  assign result_o.invalid  = (tok == cpc_pkg::TOK_INVALID) || (tok == cpc_pkg::TOK_DOTDOT);

endmodule

`default_nettype wire

// ----- src/c_punctuator_classifier.sv -----
// Top level of the C punctuator classifier: input register, decoder and result register.
// The result register loads the decoded contents of the input register while it is empty or
// not stalled, and the result transaction is offered from the result register.
// Throughput: one transaction per cycle; while a result is stalled the input register
// still takes a new transaction only if it is empty.
// Reset: rst_ni clears both valid flags asynchronously; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module c_punctuator_classifier (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [cpc_pkg::CharW-1:0]     first_char_i,
  input  wire logic [cpc_pkg::CharW-1:0]     second_char_i,
  input  wire logic [cpc_pkg::CharW-1:0]     third_char_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [cpc_pkg::TokW-1:0]           token_number_o,
  output logic [cpc_pkg::FlagsW-1:0]         category_flags_o,
  output logic [cpc_pkg::LenW-1:0]           consumed_o,
  output logic                               invalid_o
);

  logic                      in_vld_q;
  logic [cpc_pkg::CharW-1:0] first_q, second_q, third_q;
  logic                      out_vld_q;
  cpc_pkg::result_t          res_d, res_q;
  logic                      out_load, in_load;

  assign out_load   = !out_vld_q || !out_stall_i;
  assign in_stall_o = in_vld_q && !out_load;
  assign in_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (out_load) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      first_q  <= first_char_i;
      second_q <= second_char_i;
      third_q  <= third_char_i;
    end
    if (out_load && in_vld_q) begin
      res_q <= res_d;
    end
  end

  cpc_classify u_classify (
    .first_char_i  (first_q),
    .second_char_i (second_q),
    .third_char_i  (third_q),
    .result_o      (res_d)
  );

  assign out_valid_o      = out_vld_q;
  assign token_number_o   = res_q.token;
  assign category_flags_o = res_q.flags;
  assign consumed_o       = res_q.consumed;
  assign invalid_o        = res_q.invalid;

endmodule

`default_nettype wire
